// ===== design/assert_macros.svh =====
// Assertion helpers for the RTL; bfb_ctrl is the file that includes them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_CLK(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
`define ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);
`else
`define ASSERT_CLK(lbl, clk, rstn, prop, msg)
`define ASSERT_NEVER(lbl, clk, rstn, cond, msg)
`endif
`endif

// ===== design/bfb_pkg.sv =====
package bfb_pkg;

  // FILTER_BITS must be a power of two.
  localparam int TABLES      = 128;
  localparam int FILTER_BITS = 1024;
  localparam int ROW_W       = 32;
  localparam int COL_W       = $clog2(ROW_W);
  localparam int IDX_W       = $clog2(FILTER_BITS);
  localparam int ROW_BITS    = IDX_W - COL_W;
  localparam int ROWS        = FILTER_BITS / ROW_W;
  localparam int TBL_W       = (TABLES > 1) ? $clog2(TABLES) : 1;
  localparam int ADDR_W      = TBL_W + ROW_BITS;
  localparam int DEPTH       = TABLES * ROWS;
  localparam int TCMP_W      = 11;

  localparam logic [31:0] DJB_START = 32'd5381;
  localparam logic [31:0] SDBM_START = 32'd0;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_QUERY  = 2'd1,
    OP_CLEAR  = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    MEM_IDLE,
    MEM_INIT,
    MEM_CLR,
    MEM_RD,
    MEM_SETA,
    MEM_SETB
  } mem_op_t;

  typedef struct packed {
    logic    accept;
    logic    cnt_clr;
    logic    cnt_inc;
    mem_op_t mem_op;
    logic    out_load;
  } cmd_t;

  typedef struct packed {
    logic init_done;
    logic row_done;
    logic is_query;
    logic same_row;
    logic out_free;
  } stat_t;

endpackage

// ===== design/bfb_dp.sv =====
module bfb_dp (
  input  logic          clk,
  input  logic          rst_n,
  input  bfb_pkg::cmd_t cmd,
  output bfb_pkg::stat_t stat,
  input  logic [1:0]    in_op,
  input  logic [6:0]    in_table_req,
  input  logic [7:0]    in_key_byte,
  input  logic          in_last,
  input  logic          out_ready,
  output logic          out_valid,
  output logic          out_maybe_present,
  output logic          out_done_res
);
  import bfb_pkg::*;

  logic [31:0]       hash_a_r;
  logic [31:0]       hash_b_r;
  logic [31:0]       c_ext;
  logic [31:0]       hash_a_upd;
  logic [31:0]       hash_b_upd;
  logic              is_key;
  logic [6:0]        tbl_r;
  logic              tbl_ok_r;
  logic              query_r;
  logic [IDX_W-1:0]  ia_r;
  logic [IDX_W-1:0]  ib_r;
  logic [ADDR_W-1:0] cnt_r;
  logic [ROW_W-1:0]  mem [DEPTH];
  logic [ROW_W-1:0]  rd_a_r;
  logic [ROW_W-1:0]  rd_b_r;
  logic [ADDR_W-1:0] addr_a;
  logic [ADDR_W-1:0] addr_b;
  logic [ADDR_W-1:0] wr_addr;
  logic [ROW_W-1:0]  wr_data;
  logic              wr_en;
  logic [ROW_W-1:0]  bit_a;
  logic [ROW_W-1:0]  bit_b;
  logic              same_row;
  logic              present;
  logic              out_valid_r;
  logic              out_present_r;

  assign c_ext      = {{24{in_key_byte[7]}}, in_key_byte};
  assign hash_a_upd = (hash_a_r << 5) + hash_a_r + c_ext;
  assign hash_b_upd = c_ext + (hash_b_r << 6) + (hash_b_r << 16) - hash_b_r;
  assign is_key     = (in_op == OP_INSERT) || (in_op == OP_QUERY);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hash_a_r <= DJB_START;
      hash_b_r <= SDBM_START;
    end else if (cmd.accept && is_key) begin
      if (in_last) begin
        hash_a_r <= DJB_START;
        hash_b_r <= SDBM_START;
      end else begin
        hash_a_r <= hash_a_upd;
        hash_b_r <= hash_b_upd;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      tbl_r    <= in_table_req;
      tbl_ok_r <= TCMP_W'(in_table_req) < TCMP_W'(TABLES);
      query_r  <= (in_op == OP_QUERY);
      ia_r     <= hash_a_upd[IDX_W-1:0];
      ib_r     <= hash_b_upd[IDX_W-1:0];
    end
  end

  assign addr_a   = {TBL_W'(tbl_r), ia_r[IDX_W-1:COL_W]};
  assign addr_b   = {TBL_W'(tbl_r), ib_r[IDX_W-1:COL_W]};
  assign bit_a    = ROW_W'(1) << ia_r[COL_W-1:0];
  assign bit_b    = ROW_W'(1) << ib_r[COL_W-1:0];
  assign same_row = (ia_r[IDX_W-1:COL_W] == ib_r[IDX_W-1:COL_W]);

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = cnt_r;
    wr_data = '0;
    unique case (cmd.mem_op)
      MEM_IDLE: begin
      end
      MEM_INIT: begin
        wr_en = 1'b1;
      end
      MEM_CLR: begin
        wr_en   = tbl_ok_r;
        wr_addr = {TBL_W'(tbl_r), cnt_r[ROW_BITS-1:0]};
      end
      MEM_RD: begin
      end
      MEM_SETA: begin
        wr_en   = tbl_ok_r;
        wr_addr = addr_a;
        wr_data = rd_a_r | bit_a | (same_row ? bit_b : '0);
      end
      MEM_SETB: begin
        wr_en   = tbl_ok_r;
        wr_addr = addr_b;
        wr_data = rd_b_r | bit_b;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd.mem_op == MEM_RD) begin
      rd_a_r <= mem[addr_a];
      rd_b_r <= mem[addr_b];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (cmd.cnt_clr) begin
      cnt_r <= '0;
    end else if (cmd.cnt_inc) begin
      cnt_r <= cnt_r + ADDR_W'(1);
    end
  end

  assign present = query_r & tbl_ok_r & rd_a_r[ia_r[COL_W-1:0]] & rd_b_r[ib_r[COL_W-1:0]];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_present_r <= present;
    end
  end

  assign stat.init_done = (cnt_r == ADDR_W'(DEPTH - 1));
  assign stat.row_done  = (cnt_r[ROW_BITS-1:0] == '1);
  assign stat.is_query  = query_r;
  assign stat.same_row  = same_row;
  assign stat.out_free  = !out_valid_r || out_ready;

  assign out_valid         = out_valid_r;
  assign out_maybe_present = out_present_r;
  assign out_done_res      = 1'b1;

endmodule

// ===== design/bfb_ctrl.sv =====
`include "assert_macros.svh"

module bfb_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  logic [1:0]     in_op,
  input  logic           in_last,
  input  bfb_pkg::stat_t stat,
  output bfb_pkg::cmd_t  cmd
);
  import bfb_pkg::*;

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_CLR,
    S_RD,
    S_WRA,
    S_WRB,
    S_DONE
  } state_t;

  state_t state_r;
  state_t state_nxt;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt    = state_r;
    cmd.accept   = 1'b0;
    cmd.cnt_clr  = 1'b0;
    cmd.cnt_inc  = 1'b0;
    cmd.mem_op   = MEM_IDLE;
    cmd.out_load = 1'b0;
    unique case (state_r)
      S_INIT: begin
        cmd.mem_op  = MEM_INIT;
        cmd.cnt_inc = 1'b1;
        if (stat.init_done) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          if (in_op == OP_CLEAR) begin
            cmd.cnt_clr = 1'b1;
            state_nxt   = S_CLR;
          end else if ((in_op == OP_INSERT || in_op == OP_QUERY) && in_last) begin
            state_nxt = S_RD;
          end
        end
      end
      S_CLR: begin
        cmd.mem_op  = MEM_CLR;
        cmd.cnt_inc = 1'b1;
        if (stat.row_done) begin
          state_nxt = S_DONE;
        end
      end
      S_RD: begin
        cmd.mem_op = MEM_RD;
        state_nxt  = stat.is_query ? S_DONE : S_WRA;
      end
      S_WRA: begin
        cmd.mem_op = MEM_SETA;
        state_nxt  = stat.same_row ? S_DONE : S_WRB;
      end
      S_WRB: begin
        cmd.mem_op = MEM_SETB;
        state_nxt  = S_DONE;
      end
      S_DONE: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_INIT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
    end else begin
      state_r <= state_nxt;
    end
  end

  `ASSERT_CLK(a_query_no_write, clk, rst_n, (state_r == S_RD && stat.is_query) |=> (state_r == S_DONE), "query went on to write the store")
  `ASSERT_NEVER(a_load_when_full, clk, rst_n, cmd.out_load && !stat.out_free, "result loaded over a pending one")
  `ASSERT_CLK(a_second_write, clk, rst_n, (state_r == S_WRB) |-> ($past(state_r) == S_WRA && !stat.same_row), "second row write out of order")

endmodule

// ===== design/bloom_filter_bank.sv =====
// Bank of bloom filters, one bit array per table, kept in a row-wide memory.
// Input channel: in_op, in_table_req, in_key_byte, in_last with in_valid and
// in_ready. A key streams in one byte per request, and a byte that is not the
// last is absorbed into the two running hashes.
// Result channel: out_maybe_present and out_done_res with out_valid and
// out_ready. A last key byte or a clear produces exactly one result.
// From the last byte, a query reads the two rows its hashes point at and then
// loads the result; an insert reads them and writes one or two rows back
// (read-modify-write on the single write port) before it loads the result.
// A clear sweeps the table's rows at one row a cycle. While an operation is in progress in_ready is low.
// After reset the whole store is cleared one row a cycle, and in_ready stays low
// until that pass ends.
// The result sits in an output register. When the receiver stalls, new key
// bytes are still taken, and only the next finishing operation waits for it.
module bloom_filter_bank (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] in_op,
  input  logic [6:0] in_table_req,
  input  logic [7:0] in_key_byte,
  input  logic       in_last,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       out_maybe_present,
  output logic       out_done_res
);
  import bfb_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  bfb_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_op    (in_op),
    .in_last  (in_last),
    .stat     (stat),
    .cmd      (cmd)
  );

  bfb_dp u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .stat              (stat),
    .in_op             (in_op),
    .in_table_req      (in_table_req),
    .in_key_byte       (in_key_byte),
    .in_last           (in_last),
    .out_ready         (out_ready),
    .out_valid         (out_valid),
    .out_maybe_present (out_maybe_present),
    .out_done_res      (out_done_res)
  );

endmodule
